>>> rtl/core/ihex_pkg.sv
package ihex_pkg;

   localparam int DEFAULT_MAX_WORD_BYTES = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [2:0]  WORD_BYTES_RESET  = 3'd1;
   localparam logic        BIG_ENDIAN_RESET  = 1'b0;
   localparam logic [31:0] MEMORY_SIZE_RESET = 32'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WORD_BYTES  = 2'd0,
      CSR_BIG_ENDIAN  = 2'd1,
      CSR_MEMORY_SIZE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_BEGIN  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_DATA   = 2'd2
   } kind_type;

   localparam logic [7:0] REC_DATA    = 8'd0;
   localparam logic [7:0] REC_EOF     = 8'd1;
   localparam logic [7:0] REC_SEGMENT = 8'd2;
   localparam logic [7:0] REC_START   = 8'd3;
   localparam logic [7:0] REC_LINEAR  = 8'd4;

   typedef enum logic [2:0] {
      STATUS_RUNNING   = 3'd0,
      STATUS_FINISHED  = 3'd1,
      STATUS_RANGE     = 3'd2,
      STATUS_EARLY_EOF = 3'd3,
      STATUS_BAD_TYPE  = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  word_bytes;
      logic        big_endian;
      logic [31:0] memory_size;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  record_type;
      logic [15:0] record_address;
      logic [7:0]  record_length;
      logic        last_record;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic        write_valid;
      logic [31:0] write_address;
      logic [31:0] write_data;
      logic [2:0]  status;
   } result_type;

endpackage

>>> rtl/core/ihex_if.sv
interface ihex_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  record_type;
   logic [15:0] record_address;
   logic [7:0]  record_length;
   logic        last_record;
   logic [7:0]  data_byte;

   modport source (output valid, kind, record_type, record_address, record_length,
                   last_record, data_byte, input ready);
   modport sink   (input valid, kind, record_type, record_address, record_length,
                   last_record, data_byte, output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [31:0] write_address;
   logic [31:0] write_data;
   logic [2:0]  status;

   modport source (output valid, write_valid, write_address, write_data, status,
                   input ready);
   modport sink   (input valid, write_valid, write_address, write_data, status,
                   output ready);
endinterface

interface ihex_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ihex_pkg::CSR_INDEX_W-1:0] index;
   logic [ihex_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ihex_csr.sv
module ihex_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             write,
   input  logic [ihex_pkg::CSR_INDEX_W-1:0] index,
   input  logic [ihex_pkg::CSR_DATA_W-1:0]  data,
   output ihex_pkg::cfg_type                cfg
);

   ihex_pkg::cfg_type cfg_ff;
   ihex_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (ihex_pkg::csr_index_type'(index))
            ihex_pkg::CSR_WORD_BYTES:  cfg_in.word_bytes  = data[2:0];
            ihex_pkg::CSR_BIG_ENDIAN:  cfg_in.big_endian  = data[0];
            ihex_pkg::CSR_MEMORY_SIZE: cfg_in.memory_size = data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.word_bytes  <= ihex_pkg::WORD_BYTES_RESET;
         cfg_ff.big_endian  <= ihex_pkg::BIG_ENDIAN_RESET;
         cfg_ff.memory_size <= ihex_pkg::MEMORY_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/ihex_engine.sv
module ihex_engine #(
   parameter int MAX_WORD_BYTES = ihex_pkg::DEFAULT_MAX_WORD_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  ihex_pkg::cfg_type    cfg,
   input  ihex_pkg::item_type   item,
   output ihex_pkg::result_type result
);

   localparam int CNT_W  = $clog2(MAX_WORD_BYTES + 1);
   localparam int LANE_W = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
   localparam logic [CNT_W-1:0] MAX_LANES = CNT_W'(MAX_WORD_BYTES);
   localparam logic [CNT_W-1:0] ONE_LANE  = CNT_W'(1);

   logic [31:0] base_offset_ff, base_offset_in;
   logic [7:0]  current_type_ff, current_type_in;
   logic [31:0] record_base_ff, record_base_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  byte_position_ff, byte_position_in;
   logic [MAX_WORD_BYTES-1:0][7:0] accumulator_ff, accumulator_in;
   logic [CNT_W-1:0] lane_count_ff, lane_count_in;
   logic [7:0]  first_ext_ff, first_ext_in;
   ihex_pkg::status_type status_ff, status_in;
   logic        final_pending_ff, final_pending_in;

   logic [CNT_W-1:0] lanes;
   logic [CNT_W-1:0] lane;
   logic [CNT_W-1:0] target;
   logic [31:0]      header_addr;
   logic [8*MAX_WORD_BYTES+31:0] wide_word;
   logic             running;

   assign running     = (status_ff == ihex_pkg::STATUS_RUNNING);
   assign header_addr = base_offset_ff + {16'd0, item.record_address};

   always_comb begin
      if (cfg.word_bytes == 3'd0) begin
         lanes = ONE_LANE;
      end else if (32'(cfg.word_bytes) > MAX_WORD_BYTES) begin
         lanes = MAX_LANES;
      end else begin
         lanes = CNT_W'(cfg.word_bytes);
      end
      lane   = (lane_count_ff >= lanes) ? (lanes - ONE_LANE) : lane_count_ff;
      target = cfg.big_endian ? (lanes - ONE_LANE - lane) : lane;
   end

   always_comb begin
      base_offset_in   = base_offset_ff;
      current_type_in  = current_type_ff;
      record_base_in   = record_base_ff;
      bytes_left_in    = bytes_left_ff;
      byte_position_in = byte_position_ff;
      accumulator_in   = accumulator_ff;
      lane_count_in    = lane_count_ff;
      first_ext_in     = first_ext_ff;
      status_in        = status_ff;
      final_pending_in = final_pending_ff;
      wide_word        = '0;
      result.write_valid   = 1'b0;
      result.write_address = '0;
      result.write_data    = '0;

      case (item.kind)
         ihex_pkg::KIND_BEGIN: begin
            base_offset_in   = '0;
            current_type_in  = '0;
            record_base_in   = '0;
            bytes_left_in    = '0;
            byte_position_in = '0;
            accumulator_in   = '0;
            lane_count_in    = '0;
            first_ext_in     = '0;
            final_pending_in = 1'b0;
            status_in        = ihex_pkg::STATUS_RUNNING;
         end
         ihex_pkg::KIND_HEADER: begin
            if (running) begin
               current_type_in  = '0;
               record_base_in   = '0;
               bytes_left_in    = '0;
               byte_position_in = '0;
               accumulator_in   = '0;
               lane_count_in    = '0;
               first_ext_in     = '0;
               final_pending_in = 1'b0;
               if (header_addr >= cfg.memory_size) begin
                  status_in = ihex_pkg::STATUS_RANGE;
               end else if (item.record_type == ihex_pkg::REC_EOF) begin
                  status_in = item.last_record ? ihex_pkg::STATUS_FINISHED
                                               : ihex_pkg::STATUS_EARLY_EOF;
               end else if (item.record_type > ihex_pkg::REC_LINEAR) begin
                  status_in = ihex_pkg::STATUS_BAD_TYPE;
               end else begin
                  current_type_in = item.record_type;
                  record_base_in  = header_addr;
                  bytes_left_in   = item.record_length;
                  if (item.record_type == ihex_pkg::REC_SEGMENT ||
                      item.record_type == ihex_pkg::REC_LINEAR) begin
                     base_offset_in = '0;
                  end
                  if (item.last_record) begin
                     if (item.record_length == 8'd0) begin
                        status_in = ihex_pkg::STATUS_FINISHED;
                     end else begin
                        final_pending_in = 1'b1;
                     end
                  end
               end
            end
         end
         ihex_pkg::KIND_DATA: begin
            if (running && bytes_left_ff != 8'd0) begin
               case (current_type_ff)
                  ihex_pkg::REC_DATA: begin
                     accumulator_in[target[LANE_W-1:0]] =
                        accumulator_ff[target[LANE_W-1:0]] | item.data_byte;
                     lane_count_in = lane + ONE_LANE;
                     if (lane_count_in >= lanes || bytes_left_ff == 8'd1) begin
                        wide_word            = {32'd0, accumulator_in};
                        result.write_valid   = 1'b1;
                        result.write_address = record_base_ff + {24'd0, byte_position_ff}
                                               + 32'd1 - 32'(lane_count_in);
                        result.write_data    = wide_word[31:0];
                        accumulator_in       = '0;
                        lane_count_in        = '0;
                     end
                  end
                  ihex_pkg::REC_SEGMENT: begin
                     if (byte_position_ff == 8'd0) begin
                        first_ext_in   = item.data_byte;
                        base_offset_in = {12'd0, item.data_byte, 12'd0};
                     end else if (byte_position_ff == 8'd1) begin
                        base_offset_in = {12'd0, first_ext_ff, 12'd0}
                                         | {20'd0, item.data_byte, 4'd0};
                     end
                  end
                  ihex_pkg::REC_LINEAR: begin
                     if (byte_position_ff == 8'd0) begin
                        first_ext_in   = item.data_byte;
                        base_offset_in = {item.data_byte, 24'd0};
                     end else if (byte_position_ff == 8'd1) begin
                        base_offset_in = {first_ext_ff, item.data_byte, 16'd0};
                     end
                  end
                  default: ;
               endcase
               byte_position_in = byte_position_ff + 8'd1;
               bytes_left_in    = bytes_left_ff - 8'd1;
               if (bytes_left_in == 8'd0 && final_pending_ff) begin
                  final_pending_in = 1'b0;
                  status_in        = ihex_pkg::STATUS_FINISHED;
               end
            end
         end
         default: ;
      endcase

      result.status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_offset_ff   <= '0;
         current_type_ff  <= '0;
         record_base_ff   <= '0;
         bytes_left_ff    <= '0;
         byte_position_ff <= '0;
         accumulator_ff   <= '0;
         lane_count_ff    <= '0;
         first_ext_ff     <= '0;
         status_ff        <= ihex_pkg::STATUS_RUNNING;
         final_pending_ff <= 1'b0;
      end else if (accept) begin
         base_offset_ff   <= base_offset_in;
         current_type_ff  <= current_type_in;
         record_base_ff   <= record_base_in;
         bytes_left_ff    <= bytes_left_in;
         byte_position_ff <= byte_position_in;
         accumulator_ff   <= accumulator_in;
         lane_count_ff    <= lane_count_in;
         first_ext_ff     <= first_ext_in;
         status_ff        <= status_in;
         final_pending_ff <= final_pending_in;
      end
   end

endmodule

>>> rtl/core/ihex_out.sv
module ihex_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ihex_pkg::result_type result,
   input  logic                 taken,
   output logic                 free,
   output logic                 valid,
   output ihex_pkg::result_type held
);

   logic                 valid_ff, valid_in;
   ihex_pkg::result_type held_ff;

   assign free     = !valid_ff || taken;
   assign valid_in = load || (valid_ff && !taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= result;
      end
   end

   assign valid = valid_ff;
   assign held  = held_ff;

endmodule

>>> rtl/core/intel_hex_record_to_memory_writer.sv
// Loads a stream of parsed Intel HEX records into memory word writes. Send a begin item,
// then for each record its header followed by its data bytes; every accepted item yields
// exactly one result carrying the current status and, when a word completes or a data
// record ends, one write of that word's bytes at its byte address. One item is taken every
// cycle; the only stall comes from the single result register when its result is not
// taken. Configuration writes are taken at once and belong to idle periods.
module intel_hex_record_to_memory_writer #(
   parameter int MAX_WORD_BYTES = ihex_pkg::DEFAULT_MAX_WORD_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   ihex_req_if.sink   req,
   ihex_rsp_if.source rsp,
   ihex_csr_if.sink   csr
);

   ihex_pkg::cfg_type    cfg;
   ihex_pkg::item_type   item;
   ihex_pkg::result_type result;
   ihex_pkg::result_type held;
   logic                 accept;
   logic                 free;

   assign csr.ready = 1'b1;

   ihex_csr u_csr (
      .clock (clock),
      .reset (reset),
      .write (csr.valid && csr.ready),
      .index (csr.index),
      .data  (csr.data),
      .cfg   (cfg)
   );

   assign item.kind           = req.kind;
   assign item.record_type    = req.record_type;
   assign item.record_address = req.record_address;
   assign item.record_length  = req.record_length;
   assign item.last_record    = req.last_record;
   assign item.data_byte      = req.data_byte;

   assign req.ready = free;
   assign accept    = req.valid && free;

   ihex_engine #(
      .MAX_WORD_BYTES (MAX_WORD_BYTES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (cfg),
      .item   (item),
      .result (result)
   );

   ihex_out u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .result (result),
      .taken  (rsp.ready),
      .free   (free),
      .valid  (rsp.valid),
      .held   (held)
   );

   assign rsp.write_valid   = held.write_valid;
   assign rsp.write_address = held.write_address;
   assign rsp.write_data    = held.write_data;
   assign rsp.status        = held.status;

   a_accept_gives_result: assert property (
      @(posedge clock) disable iff (reset) accept |=> rsp.valid
   ) else $error("accepted item produced no result");

   a_no_write_after_error: assert property (
      @(posedge clock) disable iff (reset)
      (rsp.valid && rsp.write_valid) |->
         (rsp.status == ihex_pkg::STATUS_RUNNING || rsp.status == ihex_pkg::STATUS_FINISHED)
   ) else $error("write reported with error status");

   a_idle_result_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.write_valid) |-> (rsp.write_address == 32'd0 && rsp.write_data == 32'd0)
   ) else $error("result without write carries nonzero payload");

endmodule

>>> tb/intel_hex_record_to_memory_writer_test.sv
module intel_hex_record_to_memory_writer_test;
   import ihex_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int WORD_LANES_MAX = DEFAULT_MAX_WORD_BYTES;

   logic clock;
   logic reset;

   ihex_req_if req_bus ();
   ihex_rsp_if rsp_bus ();
   ihex_csr_if csr_bus ();

   intel_hex_record_to_memory_writer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   item_type    items_pending[$];
   result_type  load_expect[$];

   cfg_type     cfg_now;
   logic [31:0] seg_base;
   logic [31:0] rec_base;
   logic [31:0] word_acc;
   logic [7:0]  rec_type;
   logic [7:0]  rec_left;
   logic [7:0]  rec_pos;
   logic [7:0]  first_ext;
   int unsigned lane_fill;
   logic        final_due;
   status_type  run_status;

   bit failed;
   bit req_took;
   bit hold_armed;
   int hold_left;
   int send_idle;
   int recv_idle;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void clear_record();
      rec_type = REC_DATA;
      rec_base = '0;
      rec_left = '0;
      rec_pos = '0;
      word_acc = '0;
      lane_fill = 0;
      first_ext = '0;
   endfunction

   function automatic result_type load_step(item_type it);
      result_type  r;
      logic [31:0] addr;
      int unsigned lanes;
      int unsigned lane;
      int unsigned shift;
      int unsigned pos;
      r = '0;
      if (it.kind == KIND_BEGIN) begin
         seg_base = '0;
         clear_record();
         final_due = 1'b0;
         run_status = STATUS_RUNNING;
      end else if (it.kind == KIND_HEADER && run_status == STATUS_RUNNING) begin
         addr = seg_base + 32'(it.record_address);
         clear_record();
         final_due = 1'b0;
         if (addr >= cfg_now.memory_size) begin
            run_status = STATUS_RANGE;
         end else if (it.record_type == REC_EOF) begin
            run_status = it.last_record ? STATUS_FINISHED : STATUS_EARLY_EOF;
         end else if (it.record_type > REC_LINEAR) begin
            run_status = STATUS_BAD_TYPE;
         end else begin
            rec_type = it.record_type;
            rec_base = addr;
            rec_left = it.record_length;
            if (rec_type == REC_SEGMENT || rec_type == REC_LINEAR) seg_base = '0;
            if (it.last_record) begin
               if (rec_left == 0) run_status = STATUS_FINISHED;
               else final_due = 1'b1;
            end
         end
      end else if (it.kind == KIND_DATA && run_status == STATUS_RUNNING && rec_left != 0) begin
         pos = 32'(rec_pos);
         if (rec_type == REC_DATA) begin
            lanes = 32'(cfg_now.word_bytes);
            if (lanes < 1) lanes = 1;
            if (lanes > WORD_LANES_MAX) lanes = WORD_LANES_MAX;
            lane = lane_fill;
            if (lane >= lanes) lane = lanes - 1;
            shift = cfg_now.big_endian ? 8 * (lanes - 1 - lane) : 8 * lane;
            word_acc = word_acc | (32'(it.data_byte) << shift);
            lane_fill = lane + 1;
            if (lane_fill >= lanes || rec_left == 1) begin
               r.write_valid = 1'b1;
               r.write_address = rec_base + 32'(pos + 1 - lane_fill);
               r.write_data = word_acc;
               word_acc = '0;
               lane_fill = 0;
            end
         end else if (rec_type == REC_SEGMENT) begin
            if (pos == 0) begin
               first_ext = it.data_byte;
               seg_base = 32'(it.data_byte) << 12;
            end else if (pos == 1) begin
               seg_base = (32'(first_ext) << 12) | (32'(it.data_byte) << 4);
            end
         end else if (rec_type == REC_LINEAR) begin
            if (pos == 0) begin
               first_ext = it.data_byte;
               seg_base = 32'(it.data_byte) << 24;
            end else if (pos == 1) begin
               seg_base = (32'(first_ext) << 24) | (32'(it.data_byte) << 16);
            end
         end
         rec_pos = 8'(pos + 1);
         rec_left = rec_left - 8'd1;
         if (rec_left == 0 && final_due) begin
            final_due = 1'b0;
            run_status = STATUS_FINISHED;
         end
      end
      r.status = run_status;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      req_took = !reset && req_bus.valid && req_bus.ready;
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_WORD_BYTES:  cfg_now.word_bytes = csr_bus.data[2:0];
            CSR_BIG_ENDIAN:  cfg_now.big_endian = csr_bus.data[0];
            CSR_MEMORY_SIZE: cfg_now.memory_size = csr_bus.data;
            default: ;
         endcase
      end
      if (req_took) begin
         load_expect.push_back(load_step(items_pending[0]));
         items_pending.pop_front();
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (load_expect.size() == 0) begin
            $error("write result with no item outstanding");
            failed = 1'b1;
         end else begin
            want = load_expect.pop_front();
            check_field("write_valid", 32'(want.write_valid), 32'(rsp_bus.write_valid));
            check_field("write_address", want.write_address, rsp_bus.write_address);
            check_field("write_data", want.write_data, rsp_bus.write_data);
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
         end
      end
   end

   // hold the offered item until taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (items_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_bus.valid <= 1'b1;
            req_bus.kind <= items_pending[0].kind;
            req_bus.record_type <= items_pending[0].record_type;
            req_bus.record_address <= items_pending[0].record_address;
            req_bus.record_length <= items_pending[0].record_length;
            req_bus.last_record <= items_pending[0].last_record;
            req_bus.data_byte <= items_pending[0].data_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_armed && items_pending.size() > 30) begin
         hold_armed = 1'b0;
         hold_left = 150;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic queue_item(logic [1:0] k, logic [7:0] t, logic [15:0] a, logic [7:0] n,
                             logic l, logic [7:0] d);
      item_type it;
      it = '{k, t, a, n, l, d};
      items_pending.push_back(it);
   endtask

   task automatic queue_header(logic [7:0] t, logic [15:0] a, logic [7:0] n, logic l);
      queue_item(KIND_HEADER, t, a, n, l, 8'h00);
   endtask

   task automatic queue_byte(logic [7:0] d);
      queue_item(KIND_DATA, REC_DATA, 16'h0000, 8'h00, 1'b0, d);
   endtask

   task automatic queue_record_set(bit wide);
      int nrec;
      int sel;
      int len;
      int sent;
      bit close_with_eof;
      bit last;
      queue_item(KIND_BEGIN, REC_DATA, 16'h0000, 8'h00, 1'b0, 8'h00);
      nrec = $urandom_range(1, 5);
      close_with_eof = 1'($urandom_range(1));
      for (int i = 0; i < nrec; i++) begin
         last = (i == nrec - 1) && !close_with_eof;
         sel = $urandom_range(99);
         if (sel < 18) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(0, 4) : 2;
            queue_header(sel < 9 ? REC_LINEAR : REC_SEGMENT, 16'($urandom), 8'(len), last);
            for (int j = 0; j < len; j++) begin
               if (wide || (sel >= 9 && j == 1)) queue_byte(8'($urandom));
               else queue_byte(8'h00);
            end
         end else if (sel < 24) begin
            len = $urandom_range(0, 4);
            queue_header(REC_START, 16'($urandom), 8'(len), last);
            repeat (len) queue_byte(8'($urandom));
         end else begin
            len = ($urandom_range(29) == 0) ? $urandom_range(13, 90) : $urandom_range(0, 12);
            sent = ($urandom_range(14) == 0) ? $urandom_range(0, len) : len;
            queue_header(REC_DATA, 16'($urandom), 8'(len), last);
            repeat (sent) queue_byte(8'($urandom));
         end
      end
      if (close_with_eof) queue_header(REC_EOF, 16'($urandom_range(0, 255)), 8'h00, 1'b1);
   endtask

   task automatic queue_random(int count, bit wide);
      while (items_pending.size() < count) begin
         if ($urandom_range(9) < 8) begin
            queue_record_set(wide);
         end else begin
            repeat ($urandom_range(1, 4))
               queue_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                          8'($urandom), 1'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic drain();
      while (items_pending.size() != 0 || load_expect.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(logic [2:0] wb, logic be, logic [31:0] msize, int sidle, int ridle);
      drain();
      csr_write(CSR_WORD_BYTES, 32'(wb));
      csr_write(CSR_BIG_ENDIAN, 32'(be));
      csr_write(CSR_MEMORY_SIZE, msize);
      send_idle = sidle;
      recv_idle = ridle;
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_BEGIN;
      req_bus.record_type = REC_DATA;
      req_bus.record_address = '0;
      req_bus.record_length = '0;
      req_bus.last_record = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_WORD_BYTES;
      csr_bus.data = '0;
      cfg_now = '{WORD_BYTES_RESET, BIG_ENDIAN_RESET, MEMORY_SIZE_RESET};
      seg_base = '0;
      clear_record();
      final_due = 1'b0;
      run_status = STATUS_RUNNING;
      failed = 1'b0;
      req_took = 1'b0;
      hold_armed = 1'b0;
      hold_left = 0;
      send_idle = 0;
      recv_idle = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(3'd4, 1'b0, 32'd65536, 16, 77);
      queue_item(KIND_BEGIN, REC_DATA, 16'h0000, 8'h00, 1'b0, 8'h00);
      queue_header(REC_DATA, 16'h0010, 8'd5, 1'b0);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h12);
      queue_byte(8'h34);
      queue_byte(8'h56);
      queue_header(REC_SEGMENT, 16'h0000, 8'd2, 1'b0);
      queue_byte(8'h0F);
      queue_byte(8'hFF);
      queue_header(REC_DATA, 16'h0008, 8'd3, 1'b0);
      queue_byte(8'h80);
      queue_byte(8'h7F);
      queue_byte(8'hA5);
      queue_header(REC_START, 16'h0000, 8'd1, 1'b0);
      queue_byte(8'hC3);
      queue_header(REC_DATA, 16'h0100, 8'd0, 1'b0);
      queue_item(KIND_BEGIN, REC_DATA, 16'h0000, 8'h00, 1'b0, 8'h00);
      queue_header(REC_LINEAR, 16'h0000, 8'd1, 1'b0);
      queue_byte(8'h00);
      queue_header(REC_DATA, 16'hFFFF, 8'd2, 1'b1);
      queue_byte(8'hAA);
      queue_byte(8'h01);
      queue_item(KIND_BEGIN, REC_DATA, 16'h0000, 8'h00, 1'b0, 8'h00);
      queue_item(KIND_UNUSED, REC_DATA, 16'h0000, 8'h01, 1'b0, 8'h00);
      queue_byte(8'h11);
      queue_header(REC_DATA, 16'h0020, 8'd4, 1'b0);
      queue_byte(8'h22);
      queue_header(REC_EOF, 16'h0000, 8'd0, 1'b0);
      queue_item(KIND_BEGIN, REC_DATA, 16'h0000, 8'h00, 1'b0, 8'h00);
      queue_header(8'hFF, 16'h0000, 8'd0, 1'b0);
      queue_item(KIND_BEGIN, REC_DATA, 16'h0000, 8'h00, 1'b0, 8'h00);
      queue_header(REC_EOF, 16'h0000, 8'd0, 1'b1);

      configure(3'd1, 1'b1, 32'hFFFF_FFFF, 16, 77);
      hold_armed = 1'b1;
      queue_random(40, 1'b1);

      configure(3'd2, 1'b0, 32'h0000_0000, 77, 16);
      queue_random(20, 1'b0);

      configure(3'd3, 1'b1, 32'h0001_2345, 77, 16);
      queue_random(50, 1'b0);

      configure(3'd7, 1'b0, 32'd65536, 0, 0);
      queue_random(30, 1'b0);

      configure(3'd0, 1'b1, 32'hFFFF_FFFF, 0, 0);
      queue_item(KIND_BEGIN, REC_DATA, 16'h0000, 8'h00, 1'b0, 8'h00);
      queue_header(REC_DATA, 16'($urandom), 8'd130, 1'b1);
      repeat (130) queue_byte(8'($urandom));
      queue_random(140, 1'b1);

      configure(3'd4, 1'b1, 32'd65536, 0, 0);
      queue_random(40, 1'b0);

      drain();
      if (!failed) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
